FILE: rtl/ps2mt_pkg.sv
// Shared types and constants for the PS/2 mouse packet cursor tracker.
package ps2mt_pkg;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_WB
  } state_e;

  typedef enum logic [1:0] {
    PH_START,
    PH_DX,
    PH_DY,
    PH_UNUSED
  } phase_e;

  localparam logic [2:0] CFG_ENABLE  = 3'd0;
  localparam logic [2:0] CFG_DIVISOR = 3'd1;
  localparam logic [2:0] CFG_TIMEOUT = 3'd2;
  localparam logic [2:0] CFG_WIDTH   = 3'd3;
  localparam logic [2:0] CFG_HEIGHT  = 3'd4;

  localparam int unsigned SyncBit    = 3;
  localparam logic [2:0]  DivLastCnt = 3'd7;

  localparam logic [6:0] DivisorRst = 7'd10;
  localparam logic [7:0] TimeoutRst = 8'd5;
  localparam logic [7:0] WidthRst   = 8'd80;
  localparam logic [7:0] HeightRst  = 8'd25;
  localparam int unsigned PosXRst   = 40;
  localparam int unsigned PosYRst   = 12;

endpackage

FILE: rtl/ps2_mouse_packet_cursor_tracker.sv
// PS/2 mouse packet decoder with accumulated, scaled and clamped cursor tracking.
// A tick or a non-final byte is accepted without leaving idle; a packet's third byte starts
// the shared divider (8 + 8 steps for X then Y) and then one write-back that yields the result.
// Input is not ready again after a third byte until that write-back is done, and the write-back
// waits while the output register still holds the previous result.
// Reset (asynchronous, active low) restores the register defaults and parks the cursor at 40, 12.
module ps2_mouse_packet_cursor_tracker
  import ps2mt_pkg::*;
#(
  parameter int COORD_BITS = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_addr_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       func_i,
  input  logic [7:0] data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] cursor_x_o,
  output logic [7:0] cursor_y_o
);

  localparam int SW = ((COORD_BITS > 8) ? COORD_BITS : 8) + 3;
  localparam logic [SW-1:0] CoordMax = SW'((1 << COORD_BITS) - 1);

  state_e state_q, state_d;
  phase_e phase_q, phase_d, phase_eff;

  logic                  enable_q;
  logic [6:0]            divisor_q;
  logic [7:0]            timeout_q, width_q, height_q;
  logic [7:0]            elapsed_q, elapsed_d;
  logic [7:0]            held_dx_q, held_dx_d;
  logic signed [8:0]     accum_x_q, accum_x_d, accum_y_q, accum_y_d;
  logic [COORD_BITS-1:0] pos_x_q, pos_x_d, pos_y_q, pos_y_d;
  logic [7:0]            rem_q, rem_d, quo_q, quo_d;
  logic [2:0]            cnt_q, cnt_d;
  logic                  axis_q, axis_d, neg_q, neg_d;
  logic signed [8:0]     qx_q, qx_d, qy_q, qy_d;
  logic                  out_valid_q, out_valid_d;
  logic [7:0]            out_x_q, out_x_d, out_y_q, out_y_d;

  logic [6:0]        deff;
  logic signed [9:0] sum_x, sum_y;
  logic signed [8:0] mag_src, mag_full, q_signed, r_signed;
  logic [7:0]        trial, trial_sub, quo_step;
  logic              qbit;
  logic [SW-1:0]     new_x, new_y;
  logic              in_fire, out_free;

  function automatic logic [SW-1:0] clamp_f(input logic [SW-1:0] v, input logic [7:0] size);
    logic [SW-1:0] lim;
    lim = (size == 8'd0) ? '0 : SW'(size - 8'd1);
    if (lim > CoordMax) lim = CoordMax;
    if (v[SW-1]) begin
      clamp_f = '0;
    end else if (v > lim) begin
      clamp_f = lim;
    end else begin
      clamp_f = v;
    end
  endfunction

  assign deff      = (divisor_q == 7'd0) ? 7'd1 : divisor_q;
  assign sum_x     = {accum_x_q[8], accum_x_q} + {{2{held_dx_q[7]}}, held_dx_q};
  assign sum_y     = {accum_y_q[8], accum_y_q} + {{2{data_i[7]}}, data_i};
  assign mag_src   = (state_q == S_IDLE) ? sum_x[8:0] : accum_y_q;
  assign mag_full  = mag_src[8] ? -mag_src : mag_src;
  assign trial     = {rem_q[6:0], quo_q[7]};
  assign qbit      = (trial >= {1'b0, deff});
  assign trial_sub = qbit ? (trial - {1'b0, deff}) : trial;
  assign quo_step  = {quo_q[6:0], qbit};
  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire   = in_valid_i && in_ready_o;
  assign out_free  = !out_valid_q || out_ready_i;
  assign phase_eff = ((phase_q != PH_START) && (elapsed_q > timeout_q)) ? PH_START : phase_q;

  assign new_x = clamp_f(SW'(pos_x_q) + {{(SW-9){qx_q[8]}}, qx_q}, width_q);
  assign new_y = clamp_f(SW'(pos_y_q) - {{(SW-9){qy_q[8]}}, qy_q}, height_q);

  assign q_signed = neg_q ? -{1'b0, quo_step} : {1'b0, quo_step};
  assign r_signed = neg_q ? -{1'b0, trial_sub} : {1'b0, trial_sub};

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    elapsed_d   = elapsed_q;
    held_dx_d   = held_dx_q;
    accum_x_d   = accum_x_q;
    accum_y_d   = accum_y_q;
    pos_x_d     = pos_x_q;
    pos_y_d     = pos_y_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    cnt_d       = cnt_q;
    axis_d      = axis_q;
    neg_d       = neg_q;
    qx_d        = qx_q;
    qy_d        = qy_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_x_d     = out_x_q;
    out_y_d     = out_y_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_fire && enable_q) begin
          if (func_i) begin
            if (elapsed_q != 8'hFF) elapsed_d = elapsed_q + 8'd1;
          end else begin
            unique case (phase_eff)
              PH_START: begin
                phase_d = PH_START;
                if (data_i[SyncBit]) begin
                  elapsed_d = 8'd0;
                  phase_d   = PH_DX;
                end
              end
              PH_DX: begin
                held_dx_d = data_i;
                phase_d   = PH_DY;
              end
              PH_DY: begin
                phase_d   = PH_START;
                accum_x_d = sum_x[8:0];
                accum_y_d = sum_y[8:0];
                rem_d     = 8'd0;
                quo_d     = mag_full[7:0];
                neg_d     = mag_src[8];
                cnt_d     = 3'd0;
                axis_d    = 1'b0;
                state_d   = S_DIV;
              end
              default: phase_d = PH_START;
            endcase
          end
        end
      end
      S_DIV: begin
        rem_d = trial_sub;
        quo_d = quo_step;
        cnt_d = cnt_q + 3'd1;
        if (cnt_q == DivLastCnt) begin
          if (!axis_q) begin
            qx_d      = q_signed;
            accum_x_d = r_signed;
            rem_d     = 8'd0;
            quo_d     = mag_full[7:0];
            neg_d     = mag_src[8];
            axis_d    = 1'b1;
          end else begin
            qy_d      = q_signed;
            accum_y_d = r_signed;
            state_d   = S_WB;
          end
        end
      end
      S_WB: begin
        if (out_free) begin
          pos_x_d     = new_x[COORD_BITS-1:0];
          pos_y_d     = new_y[COORD_BITS-1:0];
          out_x_d     = new_x[7:0];
          out_y_d     = new_y[7:0];
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phase_q     <= PH_START;
      elapsed_q   <= 8'd0;
      accum_x_q   <= '0;
      accum_y_q   <= '0;
      pos_x_q     <= COORD_BITS'(PosXRst);
      pos_y_q     <= COORD_BITS'(PosYRst);
      out_valid_q <= 1'b0;
      cnt_q       <= 3'd0;
      axis_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      elapsed_q   <= elapsed_d;
      accum_x_q   <= accum_x_d;
      accum_y_q   <= accum_y_d;
      pos_x_q     <= pos_x_d;
      pos_y_q     <= pos_y_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
      axis_q      <= axis_d;
    end
  end

  always_ff @(posedge clk_i) begin
    held_dx_q <= held_dx_d;
    rem_q     <= rem_d;
    quo_q     <= quo_d;
    neg_q     <= neg_d;
    qx_q      <= qx_d;
    qy_q      <= qy_d;
    out_x_q   <= out_x_d;
    out_y_q   <= out_y_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q  <= 1'b0;
      divisor_q <= DivisorRst;
      timeout_q <= TimeoutRst;
      width_q   <= WidthRst;
      height_q  <= HeightRst;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_ENABLE:  enable_q  <= cfg_wdata_i[0];
        CFG_DIVISOR: divisor_q <= cfg_wdata_i[6:0];
        CFG_TIMEOUT: timeout_q <= cfg_wdata_i;
        CFG_WIDTH:   width_q   <= cfg_wdata_i;
        CFG_HEIGHT:  height_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign cursor_x_o  = out_x_q;
  assign cursor_y_o  = out_y_q;

`ifndef SYNTH
  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (rem_q < {1'b0, deff}))
    else $error("divider remainder reached the divisor");

  a_accum_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> ((accum_x_q >= -9'sd126) && (accum_x_q <= 9'sd126)
                            && (accum_y_q >= -9'sd126) && (accum_y_q <= 9'sd126)))
    else $error("remainder accumulator out of range after division");

  a_wb_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_WB) && out_free) |=> (out_valid_o && (state_q == S_IDLE)))
    else $error("write-back did not present a transaction");
`endif

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the PS/2 mouse cursor tracker with a cursor predictor.
module tb_top;
  import ps2mt_pkg::*;

  localparam logic FUNC_BYTE     = 1'b0;
  localparam logic FUNC_TICK     = 1'b1;
  localparam int   COORD_MAX     = 255;
  localparam int   IDLE_LIMIT    = 2000;
  localparam int   SETTLE_CYCLES = 24;
  localparam int   HOLD_CYCLES   = 300;

  typedef struct packed {
    logic [7:0] x;
    logic [7:0] y;
  } cursor_t;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       cfg_we_i    = 1'b0;
  logic [2:0] cfg_addr_i  = '0;
  logic [7:0] cfg_wdata_i = '0;
  logic       in_valid_i  = 1'b0;
  logic       func_i      = 1'b0;
  logic [7:0] data_i      = '0;
  logic       out_ready_i = 1'b0;
  logic       in_ready_o;
  logic       out_valid_o;
  logic [7:0] cursor_x_o;
  logic [7:0] cursor_y_o;

  logic       m_en;
  logic [6:0] m_div;
  logic [7:0] m_timeout;
  logic [7:0] m_width;
  logic [7:0] m_height;
  phase_e     m_phase;
  logic [7:0] m_dx;
  logic [7:0] m_ticks;
  int         m_acc_x;
  int         m_acc_y;
  int         m_pos_x;
  int         m_pos_y;

  cursor_t cursor_due[$];
  int      err_cnt    = 0;
  int      items_sent = 0;
  bit      in_gaps    = 1'b1;
  bit      out_gaps   = 1'b1;
  int      hold_left  = 0;
  int      out_stall  = 0;

  ps2_mouse_packet_cursor_tracker u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .func_i      (func_i),
    .data_i      (data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cursor_x_o  (cursor_x_o),
    .cursor_y_o  (cursor_y_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic void reset_model();
    m_en      = 1'b0;
    m_div     = DivisorRst;
    m_timeout = TimeoutRst;
    m_width   = WidthRst;
    m_height  = HeightRst;
    m_phase   = PH_START;
    m_dx      = '0;
    m_ticks   = '0;
    m_acc_x   = 0;
    m_acc_y   = 0;
    m_pos_x   = PosXRst;
    m_pos_y   = PosYRst;
  endfunction

  function automatic int clamp_to_screen(input int v, input logic [7:0] size);
    int lim;
    lim = (size == 8'd0) ? 0 : int'(size) - 1;
    if (lim > COORD_MAX) lim = COORD_MAX;
    if (v < 0) v = 0;
    if (v > lim) v = lim;
    return v;
  endfunction

  task automatic predict_cursor(input logic f, input logic [7:0] d);
    logic signed [7:0] sx;
    logic signed [7:0] sy;
    int                div_v;
    int                mx;
    int                my;
    cursor_t           c;
    if (!m_en) return;
    if (f == FUNC_TICK) begin
      if (m_ticks != 8'hFF) m_ticks++;
      return;
    end
    if (m_phase != PH_START && m_ticks > m_timeout) m_phase = PH_START;
    case (m_phase)
      PH_START: begin
        if (d[SyncBit]) begin
          m_ticks = '0;
          m_phase = PH_DX;
        end
      end
      PH_DX: begin
        m_dx    = d;
        m_phase = PH_DY;
      end
      default: begin
        m_phase = PH_START;
        div_v   = (m_div == 7'd0) ? 1 : int'(m_div);
        sx      = m_dx;
        sy      = d;
        m_acc_x += sx;
        m_acc_y += sy;
        mx      = m_acc_x / div_v;
        my      = m_acc_y / div_v;
        m_acc_x -= mx * div_v;
        m_acc_y -= my * div_v;
        m_pos_x = clamp_to_screen(m_pos_x + mx, m_width);
        m_pos_y = clamp_to_screen(m_pos_y - my, m_height);
        c.x     = m_pos_x[7:0];
        c.y     = m_pos_y[7:0];
        cursor_due.push_back(c);
      end
    endcase
  endtask

  always @(posedge clk_i) begin : check_cursor
    cursor_t exp_c;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (cursor_due.size() == 0) begin
        $error("unexpected transaction: cursor_x %0d cursor_y %0d", cursor_x_o, cursor_y_o);
        err_cnt++;
      end else begin
        exp_c = cursor_due.pop_front();
        if (cursor_x_o !== exp_c.x) begin
          $error("cursor_x expected %0d actual %0d", exp_c.x, cursor_x_o);
          err_cnt++;
        end
        if (cursor_y_o !== exp_c.y) begin
          $error("cursor_y expected %0d actual %0d", exp_c.y, cursor_y_o);
          err_cnt++;
        end
      end
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (out_stall > 0) begin
      out_stall--;
      out_ready_i <= 1'b0;
    end else if (out_gaps && $urandom_range(0, 5) == 0) begin
      out_stall = $urandom_range(0, 4);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle = 0;
      else idle++;
    end
    $display("ps2_mouse_packet_cursor_tracker: mismatch");
    $finish;
  end

  task automatic send_item(input logic f, input logic [7:0] d);
    if (in_gaps && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i     <= f;
    data_i     <= d;
    do @(posedge clk_i); while (!in_ready_o);
    predict_cursor(f, d);
    items_sent++;
  endtask

  task automatic send_ticks(input int n);
    repeat (n) send_item(FUNC_TICK, 8'($urandom));
  endtask

  task automatic send_packet(input logic [7:0] status, input logic [7:0] dx,
                             input logic [7:0] dy);
    send_item(FUNC_BYTE, status);
    send_item(FUNC_BYTE, dx);
    send_item(FUNC_BYTE, dy);
  endtask

  task automatic wait_until_idle();
    in_valid_i <= 1'b0;
    while (cursor_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [7:0] value);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    case (idx)
      CFG_ENABLE:  m_en      = value[0];
      CFG_DIVISOR: m_div     = value[6:0];
      CFG_TIMEOUT: m_timeout = value;
      CFG_WIDTH:   m_width   = value;
      CFG_HEIGHT:  m_height  = value;
      default: ;
    endcase
  endtask

  task automatic load_settings(input logic en, input logic [6:0] div, input logic [7:0] tmo,
                               input logic [7:0] w, input logic [7:0] h);
    write_reg(CFG_ENABLE, {7'd0, en});
    write_reg(CFG_DIVISOR, {1'b0, div});
    write_reg(CFG_TIMEOUT, tmo);
    write_reg(CFG_WIDTH, w);
    write_reg(CFG_HEIGHT, h);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [7:0] pick_delta();
    logic [7:0] s;
    s = 8'($urandom_range(0, 15));
    case ($urandom_range(0, 7))
      0:       return 8'h7F;
      1:       return 8'h80;
      2, 3:    return s - 8'd8;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick_setting(input int top, input int usual);
    case ($urandom_range(0, 5))
      0:       return 8'd0;
      1:       return 8'd1;
      2:       return 8'(top);
      default: return 8'($urandom_range(1, usual));
    endcase
  endfunction

  task automatic send_random_packet();
    int         kind;
    int         tmax;
    logic [7:0] status;
    tmax   = (m_timeout > 8'd6) ? 8 : int'(m_timeout) + 2;
    kind   = $urandom_range(0, 15);
    status = 8'($urandom);
    status[SyncBit] = 1'b1;
    if (kind == 0) send_item(FUNC_BYTE, 8'($urandom));
    else if (kind == 1) send_ticks($urandom_range(1, tmax));
    send_item(FUNC_BYTE, status);
    if ($urandom_range(0, 5) == 0) send_ticks($urandom_range(0, tmax));
    send_item(FUNC_BYTE, pick_delta());
    if (kind == 2) return;
    if ($urandom_range(0, 5) == 0) send_ticks($urandom_range(0, tmax));
    send_item(FUNC_BYTE, pick_delta());
  endtask

  task automatic test_disabled();
    send_item(FUNC_BYTE, 8'h08);
    send_ticks(2);
    send_item(FUNC_BYTE, 8'h10);
    send_item(FUNC_BYTE, 8'hF0);
    wait_until_idle();
  endtask

  task automatic test_directed();
    load_settings(1'b1, DivisorRst, TimeoutRst, WidthRst, HeightRst);
    send_item(FUNC_BYTE, 8'h00);
    send_item(FUNC_BYTE, 8'hF7);
    send_packet(8'h08, 8'h7F, 8'h80);
    send_packet(8'hFF, 8'h80, 8'h7F);
    send_packet(8'h08, 8'h05, 8'hF9);
    send_item(FUNC_BYTE, 8'h18);
    send_ticks(6);
    send_packet(8'h28, 8'h01, 8'h02);
    send_ticks(3);
    send_item(FUNC_BYTE, 8'h08);
    send_ticks(5);
    send_item(FUNC_BYTE, 8'h00);
    send_item(FUNC_BYTE, 8'h00);
    wait_until_idle();
  endtask

  task automatic test_settings_extremes();
    load_settings(1'b1, 7'd0, 8'd0, 8'd1, 8'd1);
    repeat (3) send_random_packet();
    wait_until_idle();
    load_settings(1'b1, 7'd1, 8'd255, 8'd255, 8'd255);
    send_item(FUNC_BYTE, 8'h08);
    send_ticks(260);
    send_item(FUNC_BYTE, 8'h7F);
    send_item(FUNC_BYTE, 8'h80);
    repeat (3) send_random_packet();
    wait_until_idle();
    load_settings(1'b1, 7'd127, 8'd0, 8'd0, 8'd0);
    repeat (3) send_random_packet();
    wait_until_idle();
    load_settings(1'b1, 7'd1, 8'd3, 8'd255, 8'd255);
    repeat (4) send_packet(8'h08, 8'h7F, 8'h80);
    wait_until_idle();
    load_settings(1'b1, 7'd1, 8'd3, 8'd10, 8'd5);
    send_packet(8'h08, 8'h00, 8'h00);
    send_item(FUNC_BYTE, 8'h08);
    send_item(FUNC_BYTE, 8'hF0);
    wait_until_idle();
    load_settings(1'b0, 7'd1, 8'd3, 8'd10, 8'd5);
    send_item(FUNC_BYTE, 8'h3C);
    send_ticks(8);
    wait_until_idle();
    load_settings(1'b1, 7'd2, 8'd3, 8'd10, 8'd5);
    send_item(FUNC_BYTE, 8'h11);
    wait_until_idle();
  endtask

  task automatic test_backpressure();
    load_settings(1'b1, 7'd1, 8'd20, 8'd255, 8'd255);
    hold_left = HOLD_CYCLES;
    repeat (12) send_random_packet();
    wait_until_idle();
  endtask

  task automatic test_random();
    int stop_at;
    stop_at = items_sent + 60;
    while (items_sent < stop_at) begin
      wait_until_idle();
      in_gaps  = ($urandom_range(0, 3) != 0);
      out_gaps = ($urandom_range(0, 3) != 0);
      load_settings(($urandom_range(0, 7) != 0), 7'(pick_setting(127, 40)),
                    pick_setting(255, 10), pick_setting(255, 120), pick_setting(255, 60));
      repeat (6) send_random_packet();
    end
    wait_until_idle();
  endtask

  task automatic test_final_stretch();
    in_gaps  = 1'b0;
    out_gaps = 1'b0;
    load_settings(1'b1, 7'd3, 8'd4, WidthRst, HeightRst);
    repeat (12) send_random_packet();
    wait_until_idle();
  endtask

  initial begin
    reset_model();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_disabled();
    test_directed();
    test_settings_extremes();
    test_backpressure();
    test_random();
    test_final_stretch();
    if (err_cnt == 0) begin
      $display("ps2_mouse_packet_cursor_tracker: match");
    end else begin
      $display("ps2_mouse_packet_cursor_tracker: mismatch");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/ps2mt_pkg.sv
rtl/ps2_mouse_packet_cursor_tracker.sv
sim/tb_top.sv
